// File: hw/rtl/pva_pkg.sv
`default_nettype none

package pva_pkg;

	// fixed field widths of the request and result transactions
	localparam int MODE_W   = 2;
	localparam int VIDX_W   = 4;
	localparam int PRIO_W   = 8;
	localparam int TIME_W   = 32;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int PITCH_W  = 16;

	// request operation codes
	typedef enum logic [MODE_W-1:0] {
		OP_PLAY = 2'd0,
		OP_STOP = 2'd1,
		OP_FREE = 2'd2,
		OP_NONE = 2'd3
	} pva_op_t;

	// voice table modes
	typedef enum logic [1:0] {
		VM_FREE = 2'd0,
		VM_PLAY = 2'd1,
		VM_LOOP = 2'd2,
		VM_ERR  = 2'd3
	} pva_vmode_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_DRAIN  = 2'd2,
		ST_DECIDE = 2'd3
	} pva_state_t;

	// control part of one voice entry fed to the scan unit
	typedef struct packed {
		logic       valid;
		logic       running;
		pva_vmode_t mode;
	} pva_entry_t;

	// scan unit status
	typedef struct packed {
		logic free_found;
		logic steal_found;
	} pva_scan_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pva_req_if.sv
`default_nettype none

interface pva_req_if;

	logic                           valid;
	logic                           ready;
	logic [pva_pkg::MODE_W-1:0]     mode;
	logic [pva_pkg::VIDX_W-1:0]     voice_index;
	logic [pva_pkg::PRIO_W-1:0]     priority_req;
	logic [pva_pkg::TIME_W-1:0]     timestamp;
	logic [pva_pkg::SAMPLE_W-1:0]   sample_id;
	logic [pva_pkg::GAIN_W-1:0]     gain;
	logic [pva_pkg::PITCH_W-1:0]    pitch;
	logic                           looping;
	logic                           start_failed;

	modport source (
		output valid, mode, voice_index, priority_req, timestamp, sample_id,
		       gain, pitch, looping, start_failed,
		input  ready
	);

	modport sink (
		input  valid, mode, voice_index, priority_req, timestamp, sample_id,
		       gain, pitch, looping, start_failed,
		output ready
	);

endinterface

`default_nettype wire

// File: hw/rtl/pva_res_if.sv
`default_nettype none

interface pva_res_if;

	logic                           valid;
	logic                           ready;
	logic                           granted;
	logic [pva_pkg::VIDX_W-1:0]     voice;
	logic                           stolen;
	logic [pva_pkg::SAMPLE_W-1:0]   out_sample_id;
	logic [pva_pkg::GAIN_W-1:0]     out_gain;
	logic [pva_pkg::PITCH_W-1:0]    out_pitch;
	logic                           out_looping;

	modport source (
		output valid, granted, voice, stolen, out_sample_id, out_gain, out_pitch,
		       out_looping,
		input  ready
	);

	modport sink (
		input  valid, granted, voice, stolen, out_sample_id, out_gain, out_pitch,
		       out_looping,
		output ready
	);

endinterface

`default_nettype wire

// File: hw/rtl/pva_scan.sv
`default_nettype none

module pva_scan #(
	parameter int VOICES        = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic [PRIORITY_BITS-1:0]      req_prio,
	input  pva_pkg::pva_entry_t           entry,
	input  logic [$clog2(VOICES)-1:0]     entry_idx,
	input  logic [PRIORITY_BITS-1:0]      entry_prio,
	input  logic [pva_pkg::TIME_W-1:0]    entry_start,
	output pva_pkg::pva_scan_stat_t       stat,
	output logic [$clog2(VOICES)-1:0]     free_idx,
	output logic [$clog2(VOICES)-1:0]     steal_idx
);

	import pva_pkg::*;

	localparam int ADDR_W = $clog2(VOICES);

	logic                     free_found_q;
	logic                     have_q;
	logic [ADDR_W-1:0]        free_idx_q;
	logic [ADDR_W-1:0]        best_idx_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic [TIME_W-1:0]        best_time_q;

	logic is_free;
	logic is_cand;
	logic prio_eq;
	logic prio_lt;
	logic time_lt;
	logic take;

	// shared compare unit: one entry per cycle
	always_comb begin
		is_free = (entry.mode == VM_FREE) || !entry.running;
		is_cand = !is_free && ((entry.mode == VM_PLAY) || (entry.mode == VM_ERR));
		prio_eq = (entry_prio == best_prio_q);
		prio_lt = (entry_prio < best_prio_q);
		time_lt = (entry_start < best_time_q);
		take    = entry.valid && is_cand && (prio_lt || (prio_eq && (!have_q || time_lt)));
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			have_q       <= 1'b0;
		end else if (clear) begin
			free_found_q <= 1'b0;
			have_q       <= 1'b0;
		end else begin
			if (entry.valid && is_free) begin
				free_found_q <= 1'b1;
			end
			if (take) begin
				have_q <= 1'b1;
			end
		end
	end

	// best candidate and first free voice
	always_ff @(posedge clk) begin
		if (clear) begin
			best_prio_q <= req_prio;
		end else begin
			if (entry.valid && is_free && !free_found_q) begin
				free_idx_q <= entry_idx;
			end
			if (take) begin
				best_idx_q  <= entry_idx;
				best_prio_q <= entry_prio;
				best_time_q <= entry_start;
			end
		end
	end

	assign stat.free_found  = free_found_q;
	assign stat.steal_found = have_q;
	assign free_idx         = free_idx_q;
	assign steal_idx        = best_idx_q;

`ifndef ASSERT_OFF
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (!free_found_q && !have_q))
		else $error("scan state not cleared");

	a_free_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(free_found_q && !clear) |=> (free_found_q && $stable(free_idx_q)))
		else $error("first free voice changed during scan");

	a_prio_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(have_q && !clear) |=> (best_prio_q <= $past(best_prio_q)))
		else $error("steal priority rose during scan");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/priority_voice_allocator_unit.sv
// Priority voice allocator with lowest-priority, oldest-first stealing.
// req channel (valid/ready): one event per transaction. A play request
// takes the first voice that is free or no longer running, otherwise steals
// the lowest priority playing or errored voice at or below its own priority,
// oldest start time on a tie. Stop and free events update the named voice.
// res channel (valid/ready): exactly one result per request transaction.
// cfg_we/cfg_wdata write the muted bit; write it only while the block is idle.
// A play request that is not muted and has a nonzero sample id walks
// the voice table one entry per cycle through the shared compare unit, even
// when no voice turns out to be available; a drain state and then the decide
// state follow, the decide state registers the result, and the block returns
// to idle to take the next request. Stop, free, unused-op, muted or bad-id
// requests skip the walk and go straight from idle to the decide state.
// Reset clears all voices to free and not running and clears muted; no
// clearing pass is needed. A stalled receiver holds the result register;
// one more request may be accepted meanwhile and waits before its update.
`default_nettype none

module priority_voice_allocator_unit #(
	parameter int VOICES        = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	pva_req_if.sink    req,
	pva_res_if.source  res
);

	import pva_pkg::*;

	localparam int ADDR_W = $clog2(VOICES);

	// configuration
	logic muted_q;

	// sequencer
	pva_state_t state_q, state_d;
	logic       req_ready;
	logic       rd_en;
	logic       res_load;
	logic       accept;

	// latched request
	logic [MODE_W-1:0]        mode_q;
	logic [VIDX_W-1:0]        vidx_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [TIME_W-1:0]        ts_q;
	logic [SAMPLE_W-1:0]      sid_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [PITCH_W-1:0]       pitch_q;
	logic                     loop_q;
	logic                     fail_q;
	logic                     play_q;

	// voice table
	pva_vmode_t               vmode_q [VOICES];
	logic                     running_q [VOICES];
	logic [PRIORITY_BITS-1:0] prio_mem [VOICES];
	logic [TIME_W-1:0]        start_mem [VOICES];

	// scan pipeline
	logic [ADDR_W-1:0]        scan_idx_q;
	pva_entry_t               entry_s1;
	logic [ADDR_W-1:0]        idx_s1;
	logic [PRIORITY_BITS-1:0] prio_s1;
	logic [TIME_W-1:0]        start_s1;
	pva_scan_stat_t           scan_stat;
	logic [ADDR_W-1:0]        free_idx;
	logic [ADDR_W-1:0]        steal_idx;

	// decision
	logic              chosen_ok;
	logic [ADDR_W-1:0] chosen;
	logic              do_start;
	logic              idx_ok;
	logic [ADDR_W-1:0] vaddr;
	logic              play_ok_in;

	// result register
	logic                res_valid_q;
	logic                granted_q;
	logic [VIDX_W-1:0]   voice_q;
	logic                stolen_q;
	logic [SAMPLE_W-1:0] osid_q;
	logic [GAIN_W-1:0]   ogain_q;
	logic [PITCH_W-1:0]  opitch_q;
	logic                oloop_q;

	assign accept     = req.valid && req_ready;
	assign play_ok_in = (req.mode == OP_PLAY) && !muted_q && (req.sample_id != '0);

	// muted register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			muted_q <= 1'b0;
		end else if (cfg_we) begin
			muted_q <= cfg_wdata;
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rd_en     = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					state_d = play_ok_in ? ST_SCAN : ST_DECIDE;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_idx_q == ADDR_W'(VOICES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!res_valid_q || res.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req.ready = req_ready;

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= req.mode;
			vidx_q  <= req.voice_index;
			prio_q  <= PRIORITY_BITS'(req.priority_req);
			ts_q    <= req.timestamp;
			sid_q   <= req.sample_id;
			gain_q  <= req.gain;
			pitch_q <= req.pitch;
			loop_q  <= req.looping;
			fail_q  <= req.start_failed;
			play_q  <= play_ok_in;
		end
	end

	// scan address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (accept) begin
			scan_idx_q <= '0;
		end else if (rd_en) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	// priority and start time memories, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			prio_s1  <= prio_mem[scan_idx_q];
			start_s1 <= start_mem[scan_idx_q];
		end
		if (res_load && do_start) begin
			prio_mem[chosen]  <= prio_q;
			start_mem[chosen] <= ts_q;
		end
	end

	// entry control alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_s1 <= '0;
			idx_s1   <= '0;
		end else begin
			entry_s1.valid <= rd_en;
			if (rd_en) begin
				entry_s1.running <= running_q[scan_idx_q];
				entry_s1.mode    <= vmode_q[scan_idx_q];
				idx_s1           <= scan_idx_q;
			end
		end
	end

	pva_scan #(
		.VOICES        (VOICES),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (accept),
		.req_prio    (PRIORITY_BITS'(req.priority_req)),
		.entry       (entry_s1),
		.entry_idx   (idx_s1),
		.entry_prio  (prio_s1),
		.entry_start (start_s1),
		.stat        (scan_stat),
		.free_idx    (free_idx),
		.steal_idx   (steal_idx)
	);

	// voice choice
	always_comb begin
		chosen_ok = play_q && (scan_stat.free_found || scan_stat.steal_found);
		chosen    = scan_stat.free_found ? free_idx : steal_idx;
		do_start  = chosen_ok && !fail_q;
		idx_ok    = (32'(vidx_q) < 32'(VOICES));
		vaddr     = ADDR_W'(vidx_q);
	end

	// voice mode and running flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				vmode_q[i]   <= VM_FREE;
				running_q[i] <= 1'b0;
			end
		end else if (res_load) begin
			if (chosen_ok) begin
				if (fail_q) begin
					vmode_q[chosen]   <= VM_ERR;
					running_q[chosen] <= 1'b0;
				end else begin
					vmode_q[chosen]   <= loop_q ? VM_LOOP : VM_PLAY;
					running_q[chosen] <= 1'b1;
				end
			end else if ((mode_q == OP_STOP) && idx_ok) begin
				running_q[vaddr] <= 1'b0;
			end else if ((mode_q == OP_FREE) && idx_ok) begin
				vmode_q[vaddr]   <= VM_FREE;
				running_q[vaddr] <= 1'b0;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, zero unless a voice was chosen
	always_ff @(posedge clk) begin
		if (res_load) begin
			granted_q <= do_start;
			voice_q   <= chosen_ok ? VIDX_W'(chosen) : '0;
			stolen_q  <= chosen_ok && !scan_stat.free_found;
			osid_q    <= chosen_ok ? sid_q : '0;
			ogain_q   <= chosen_ok ? gain_q : '0;
			opitch_q  <= chosen_ok ? pitch_q : '0;
			oloop_q   <= chosen_ok && loop_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.granted       = granted_q;
	assign res.voice         = voice_q;
	assign res.stolen        = stolen_q;
	assign res.out_sample_id = osid_q;
	assign res.out_gain      = ogain_q;
	assign res.out_pitch     = opitch_q;
	assign res.out_looping   = oloop_q;

`ifndef ASSERT_OFF
	a_grant_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (granted_q || stolen_q)) |-> (osid_q != '0))
		else $error("voice given to a request with a bad sample id");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_idx_q == ADDR_W'(VOICES - 1)) |=> (state_q == ST_DRAIN))
		else $error("scan did not stop after the last voice");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (state_q == ST_IDLE && res_valid_q))
		else $error("result not presented after decision");
`endif

endmodule

`default_nettype wire

// File: tb/sv/priority_voice_allocator_unit_tb.sv
`timescale 1ns / 100ps

module priority_voice_allocator_unit_tb;

	import pva_pkg::*;

	localparam int NUM_VOICES  = 16;
	localparam int IDLE_LIMIT  = 1000;
	localparam int MAX_REPORTS = 10;

	// one request transaction
	typedef struct packed {
		pva_op_t             op;
		logic [VIDX_W-1:0]   idx;
		logic [PRIO_W-1:0]   prio;
		logic [TIME_W-1:0]   ts;
		logic [SAMPLE_W-1:0] sid;
		logic [GAIN_W-1:0]   gain;
		logic [PITCH_W-1:0]  pitch;
		logic                loop;
		logic                fail;
	} voice_event_t;

	// one result transaction
	typedef struct packed {
		logic                granted;
		logic [VIDX_W-1:0]   voice;
		logic                stolen;
		logic [SAMPLE_W-1:0] sid;
		logic [GAIN_W-1:0]   gain;
		logic [PITCH_W-1:0]  pitch;
		logic                loop;
	} voice_grant_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	pva_req_if req_ch ();
	pva_res_if res_ch ();

	priority_voice_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the voice table and the mute bit
	pva_vmode_t        shadow_mode [NUM_VOICES];
	logic [PRIO_W-1:0] shadow_prio [NUM_VOICES];
	logic [TIME_W-1:0] shadow_start [NUM_VOICES];
	logic              shadow_run [NUM_VOICES];
	logic              shadow_muted;

	voice_grant_t grant_q[$];

	int mismatches = 0;
	int n_events = 0;
	int n_grants = 0;
	int n_steals = 0;
	int n_refused = 0;
	int n_failed = 0;
	int n_mute_writes = 0;

	int burst_left = 0;
	logic [TIME_W-1:0] tick = '0;

	logic req_fire = 1'b0;
	logic res_fire = 1'b0;
	int idle_cycles = 0;

	// result path pacing state
	int rx_style = 0;
	int rx_style_left = 0;
	int rx_run_left = 0;
	logic rx_phase = 1'b0;

	voice_grant_t got_grant;
	voice_grant_t want_grant;

	// allocation decision and table update for one transaction
	function automatic voice_grant_t predict_grant(input voice_event_t ev);
		voice_grant_t g;
		int i;
		int pick;
		int best;
		logic have;
		logic steal;
		logic [PRIO_W-1:0] best_prio;
		logic [TIME_W-1:0] best_time;
		g = '0;
		n_events++;
		case (ev.op)
			OP_STOP: begin
				shadow_run[ev.idx] = 1'b0;
			end
			OP_FREE: begin
				shadow_mode[ev.idx] = VM_FREE;
				shadow_run[ev.idx] = 1'b0;
			end
			OP_PLAY: begin
				pick = -1;
				best = 0;
				have = 1'b0;
				steal = 1'b0;
				best_prio = ev.prio;
				best_time = '0;
				if (!shadow_muted && ev.sid != '0) begin
					// first free or stopped voice, else track the steal candidate
					for (i = 0; i < NUM_VOICES; i++) begin
						if (pick < 0) begin
							if (shadow_mode[i] == VM_FREE || !shadow_run[i]) begin
								pick = i;
							end else if ((shadow_mode[i] == VM_PLAY || shadow_mode[i] == VM_ERR) &&
									shadow_prio[i] <= best_prio) begin
								if (shadow_prio[i] == best_prio) begin
									if (!have || shadow_start[i] < best_time) begin
										have = 1'b1;
										best = i;
										best_time = shadow_start[i];
									end
								end else begin
									have = 1'b1;
									best = i;
									best_prio = shadow_prio[i];
									best_time = shadow_start[i];
								end
							end
						end
					end
					if (pick < 0 && have) begin
						pick = best;
						steal = 1'b1;
					end
				end
				if (pick < 0) begin
					n_refused++;
				end else begin
					if (ev.fail) begin
						shadow_mode[pick] = VM_ERR;
						shadow_run[pick] = 1'b0;
						n_failed++;
					end else begin
						if (ev.loop) begin
							shadow_mode[pick] = VM_LOOP;
						end else begin
							shadow_mode[pick] = VM_PLAY;
						end
						shadow_prio[pick] = ev.prio;
						shadow_start[pick] = ev.ts;
						shadow_run[pick] = 1'b1;
						n_grants++;
					end
					if (steal) begin
						n_steals++;
					end
					g.granted = !ev.fail;
					g.voice = VIDX_W'(pick);
					g.stolen = steal;
					g.sid = ev.sid;
					g.gain = ev.gain;
					g.pitch = ev.pitch;
					g.loop = ev.loop;
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	function automatic voice_event_t make_event(input pva_op_t op, input logic [VIDX_W-1:0] idx,
			input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] ts,
			input logic [SAMPLE_W-1:0] sid, input logic [GAIN_W-1:0] gain,
			input logic [PITCH_W-1:0] pitch, input logic loop, input logic fail);
		voice_event_t ev;
		ev.op = op;
		ev.idx = idx;
		ev.prio = prio;
		ev.ts = ts;
		ev.sid = sid;
		ev.gain = gain;
		ev.pitch = pitch;
		ev.loop = loop;
		ev.fail = fail;
		return ev;
	endfunction

	// mostly plays and stops over a running clock, some frees and noise
	function automatic voice_event_t random_event();
		voice_event_t ev;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 62) begin
			ev.op = OP_PLAY;
		end else if (sel < 78) begin
			ev.op = OP_STOP;
		end else if (sel < 92) begin
			ev.op = OP_FREE;
		end else begin
			ev.op = OP_NONE;
		end
		if ($urandom_range(0, 15) == 0) begin
			tick = $urandom();
		end else begin
			tick = tick + TIME_W'($urandom_range(0, 3));
		end
		ev.idx = VIDX_W'($urandom_range(0, NUM_VOICES - 1));
		if ($urandom_range(0, 3) != 0) begin
			ev.prio = PRIO_W'($urandom_range(0, 7));
		end else begin
			ev.prio = PRIO_W'($urandom_range(0, 255));
		end
		ev.ts = tick;
		ev.sid = ($urandom_range(0, 24) == 0) ? '0 : SAMPLE_W'($urandom_range(1, 65535));
		ev.gain = GAIN_W'($urandom());
		ev.pitch = PITCH_W'($urandom());
		ev.loop = ($urandom_range(0, 5) == 0);
		ev.fail = ($urandom_range(0, 7) == 0);
		return ev;
	endfunction

	// send one transaction in bursts separated by random gaps
	task automatic send_item(input voice_event_t ev);
		int gap;
		logic rdy;
		voice_grant_t exp_grant;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= ev.op;
		req_ch.voice_index <= ev.idx;
		req_ch.priority_req <= ev.prio;
		req_ch.timestamp <= ev.ts;
		req_ch.sample_id <= ev.sid;
		req_ch.gain <= ev.gain;
		req_ch.pitch <= ev.pitch;
		req_ch.looping <= ev.loop;
		req_ch.start_failed <= ev.fail;
		do begin
			@(negedge clk);
			rdy = req_ch.ready;
			@(posedge clk);
		end while (!rdy);
		exp_grant = predict_grant(ev);
		grant_q.insert(grant_q.size(), exp_grant);
		burst_left--;
	endtask

	// hold off the sender until every outstanding result is back
	task automatic settle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (grant_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_muted(input logic value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_muted = value;
		n_mute_writes++;
	endtask

	// fill the table, steal, refuse, stop, free, failed start, unused op
	task automatic test_directed_table();
		int i;
		send_item(make_event(OP_PLAY, 4'h0, 8'h00, 32'h0, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
		for (i = 1; i < NUM_VOICES; i++) begin
			send_item(make_event(OP_PLAY, VIDX_W'(NUM_VOICES - 1 - i), 8'd200, TIME_W'(i * 100),
				SAMPLE_W'(i), 16'hFFFF, 16'h0000, (i == 3), 1'b0));
		end
		// lowest priority goes first, request must be at or above it
		send_item(make_event(OP_PLAY, 4'h0, 8'd100, 32'hFFFF_FFFF, 16'h0001, 16'h1000, 16'h1000,
			1'b0, 1'b0));
		send_item(make_event(OP_PLAY, 4'h0, 8'd50, 32'd10, 16'h0002, 16'h1000, 16'h1000, 1'b0, 1'b0));
		// equal priorities, oldest start time is taken
		send_item(make_event(OP_PLAY, 4'h0, 8'd200, 32'd7, 16'h0003, 16'h0800, 16'h2000, 1'b0, 1'b0));
		send_item(make_event(OP_PLAY, 4'h0, 8'd200, 32'd8, 16'h0004, 16'h0800, 16'h2000, 1'b0, 1'b0));
		// bad sample id
		send_item(make_event(OP_PLAY, 4'hF, 8'hFF, 32'd9, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
		// stopped voice is reused without stealing
		send_item(make_event(OP_STOP, 4'h5, 8'h00, 32'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
		send_item(make_event(OP_PLAY, 4'h0, 8'd1, 32'd11, 16'hABCD, 16'h1234, 16'h4321, 1'b1, 1'b0));
		// freed voice whose start fails goes to error
		send_item(make_event(OP_FREE, 4'h9, 8'h00, 32'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
		send_item(make_event(OP_PLAY, 4'h0, 8'd3, 32'd12, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b1));
		send_item(make_event(OP_NONE, 4'hF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 1'b1));
		// failed start on the errored, not running voice reuses it and still reports the voice
		send_item(make_event(OP_PLAY, 4'h0, 8'hFF, 32'd13, 16'h7777, 16'h0001, 16'h0001, 1'b0, 1'b1));
		send_item(make_event(OP_PLAY, 4'h0, 8'hFF, 32'd14, 16'h8888, 16'h0002, 16'h0002, 1'b0, 1'b1));
	endtask

	// muted: every play refused, stop and free still act
	task automatic test_mute_refusal();
		set_muted(1'b1);
		send_item(make_event(OP_PLAY, 4'h0, 8'hFF, 32'd20, 16'h1111, 16'h0001, 16'h0001, 1'b0, 1'b0));
		send_item(make_event(OP_STOP, 4'h2, 8'h00, 32'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
		send_item(make_event(OP_FREE, 4'hC, 8'h00, 32'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
		send_item(make_event(OP_PLAY, 4'h0, 8'h00, 32'd21, 16'h2222, 16'h0001, 16'h0001, 1'b1, 1'b0));
		set_muted(1'b0);
		send_item(make_event(OP_PLAY, 4'h0, 8'h00, 32'd22, 16'h3333, 16'h0001, 16'h0001, 1'b0, 1'b0));
	endtask

	task automatic test_random_traffic(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_item(random_event());
		end
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch on %s at %0t: expected %0h, got %0h", field, $realtime, want, got);
		end
	endtask

	// result checking, sampled away from the driving edge
	always @(negedge clk) begin
		req_fire <= arst_n && req_ch.valid && req_ch.ready;
		res_fire <= arst_n && res_ch.valid && res_ch.ready;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got_grant.granted = res_ch.granted;
			got_grant.voice = res_ch.voice;
			got_grant.stolen = res_ch.stolen;
			got_grant.sid = res_ch.out_sample_id;
			got_grant.gain = res_ch.out_gain;
			got_grant.pitch = res_ch.out_pitch;
			got_grant.loop = res_ch.out_looping;
			if (grant_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch: result with nothing expected, voice %0d", got_grant.voice);
				end
			end else begin
				want_grant = grant_q.pop_front();
				if (got_grant.granted !== want_grant.granted)
					note_mismatch("granted", 32'(want_grant.granted), 32'(got_grant.granted));
				if (got_grant.voice !== want_grant.voice)
					note_mismatch("voice", 32'(want_grant.voice), 32'(got_grant.voice));
				if (got_grant.stolen !== want_grant.stolen)
					note_mismatch("stolen", 32'(want_grant.stolen), 32'(got_grant.stolen));
				if (got_grant.sid !== want_grant.sid)
					note_mismatch("out_sample_id", 32'(want_grant.sid), 32'(got_grant.sid));
				if (got_grant.gain !== want_grant.gain)
					note_mismatch("out_gain", 32'(want_grant.gain), 32'(got_grant.gain));
				if (got_grant.pitch !== want_grant.pitch)
					note_mismatch("out_pitch", 32'(want_grant.pitch), 32'(got_grant.pitch));
				if (got_grant.loop !== want_grant.loop)
					note_mismatch("out_looping", 32'(want_grant.loop), 32'(got_grant.loop));
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_fire || res_fire) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result ready pattern: always, sparse, dense, or long stall runs
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_style_left == 0) begin
				rx_style = $urandom_range(0, 3);
				rx_style_left = $urandom_range(50, 150);
			end
			rx_style_left--;
			case (rx_style)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= ($urandom_range(0, 3) != 0);
				2: begin
					if (rx_run_left == 0) begin
						rx_phase = !rx_phase;
						rx_run_left = rx_phase ? $urandom_range(1, 8) : $urandom_range(1, 20);
					end
					rx_run_left--;
					res_ch.ready <= rx_phase;
				end
				default: res_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		int i;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= OP_PLAY;
		req_ch.voice_index <= '0;
		req_ch.priority_req <= '0;
		req_ch.timestamp <= '0;
		req_ch.sample_id <= '0;
		req_ch.gain <= '0;
		req_ch.pitch <= '0;
		req_ch.looping <= 1'b0;
		req_ch.start_failed <= 1'b0;
		for (i = 0; i < NUM_VOICES; i++) begin
			shadow_mode[i] = VM_FREE;
			shadow_prio[i] = '0;
			shadow_start[i] = '0;
			shadow_run[i] = 1'b0;
		end
		shadow_muted = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_muted(1'b0);
		test_directed_table();
		test_mute_refusal();
		test_random_traffic(600);
		settle();
		test_random_traffic(250);
		set_muted(1'b1);
		test_random_traffic(150);
		set_muted(1'b0);
		test_random_traffic(650);

		settle();
		repeat (NUM_VOICES + 4) @(posedge clk);
		$display("summary: %0d requests, %0d grants, %0d steals, %0d refused plays, %0d failed starts",
			n_events, n_grants, n_steals, n_refused, n_failed);
		$display("summary: %0d mute writes, %0d mismatches, %0d results outstanding",
			n_mute_writes, mismatches, grant_q.size());
		if (mismatches == 0 && grant_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
